FILE: rtl/brlh_pkg.sv
// Shared types and constants for the binary run-length histogram block.
package brlh_pkg;

    localparam int MAX_LEN_DEF    = 1023;
    localparam int COUNT_BITS_DEF = 32;
    localparam int IDX_W          = 10;
    localparam int OUT_CNT_W      = 32;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic             sample_bit;
        logic [IDX_W-1:0] length_index;
    } t_in_item;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] zero_runs;
        logic [OUT_CNT_W-1:0] one_runs;
        logic [IDX_W-1:0]     longest_run;
        logic                 overflow;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic inc_en;
        logic inc_bit;
        logic clr_start;
    } t_hist_req;

    typedef enum logic {
        ST_IDLE,
        ST_MEM
    } t_state;

endpackage

FILE: rtl/brlh_hist.sv
// Histogram store: one memory holding both counts per length, with increment and clear sweep.
module brlh_hist
    import brlh_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int HIST_DEPTH = MAX_LEN + 1,
    localparam int ADDR_W     = $clog2(HIST_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_hist_req             i_req,
    input  logic [ADDR_W-1:0]     i_addr,
    output logic [COUNT_BITS-1:0] o_rd_zero,
    output logic [COUNT_BITS-1:0] o_rd_one,
    output logic                  o_busy
);

    // Each word holds {one-run count, zero-run count}.
    logic [2*COUNT_BITS-1:0] r_mem [HIST_DEPTH];
    logic [2*COUNT_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]       r_wr_addr;
    logic                    r_inc_pend;
    logic                    r_inc_bit;
    logic                    r_clr_active;
    logic [ADDR_W-1:0]       r_clr_addr;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [2*COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0]   old_zero;
    logic [COUNT_BITS-1:0]   old_one;
    logic [COUNT_BITS-1:0]   new_zero;
    logic [COUNT_BITS-1:0]   new_one;

    assign old_zero = r_rd_data[COUNT_BITS-1:0];
    assign old_one  = r_rd_data[2*COUNT_BITS-1:COUNT_BITS];

    always_comb begin
        new_zero = old_zero;
        new_one  = old_one;
        if (!r_inc_bit) begin
            if (old_zero != '1) begin
                new_zero = old_zero + COUNT_BITS'(1);
            end
        end else begin
            if (old_one != '1) begin
                new_one = old_one + COUNT_BITS'(1);
            end
        end
    end

    // The sweep and the increment write never coincide: the top level
    // accepts no item while either is in progress.
    always_comb begin
        wr_en   = r_clr_active || r_inc_pend;
        wr_addr = r_clr_active ? r_clr_addr : r_wr_addr;
        wr_data = r_clr_active ? '0 : {new_one, new_zero};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_wr_addr <= i_addr;
            r_inc_bit <= i_req.inc_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_pend   <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_inc_pend <= i_req.rd_en && i_req.inc_en;
            if (i_req.clr_start) begin
                r_clr_active <= 1'b1;
                r_clr_addr   <= '0;
            end else if (r_clr_active) begin
                if (r_clr_addr == ADDR_W'(MAX_LEN)) begin
                    r_clr_active <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    assign o_rd_zero = old_zero;
    assign o_rd_one  = old_one;
    assign o_busy    = r_clr_active;

endmodule

FILE: rtl/binary_run_length_histogram_top.sv
// Binary run-length histogram: top level with run tracking, control and output staging.
//
// Usage: each input transfer on i_in carries an op (bit sample, read entry, clear)
// and produces exactly one result transfer on o_out. Both channels use valid/stall.
// Items are worked one at a time. A sample that does not close a run, an unused op
// and a read of a length outside 1..MAX_LEN need no memory access; a sample that
// closes a run and a read in range pass through the memory access state, because
// the histogram memory read is registered and the count is written back in that
// state. A clear is followed by the memory sweep described below.
// The result is registered: it appears on o_out the cycle after the transfer, or
// after the memory read cycle for a read. A result that meets a stalled receiver
// waits in a one-entry holding register; the block then takes no further item
// until the holding register drains, and o_out holds steady while stalled.
// Reset and every clear item start a sweep that zeroes all MAX_LEN + 1 entries of
// the histogram memory (1024 at the default), one entry per cycle; input is stalled
// during the sweep. The clear item's own result is delivered right away.
module binary_run_length_histogram_top
    import brlh_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    t_state            r_state;
    t_state            n_state;
    logic              r_mem_read;
    logic              n_mem_read;
    logic              r_started;
    logic              n_started;
    logic              r_cur_bit;
    logic              n_cur_bit;
    logic [LEN_W-1:0]  r_cur_len;
    logic [LEN_W-1:0]  n_cur_len;
    logic              r_ovf;
    logic              n_ovf;
    logic [LEN_W-1:0]  r_longest;
    logic [LEN_W-1:0]  n_longest;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_hold_valid;
    t_out_item         r_hold;

    logic                  in_fire;
    logic                  out_free;
    logic                  idx_ok;
    logic                  cur_res_valid;
    t_out_item             cur_res;
    t_hist_req             hist_req;
    logic [LEN_W-1:0]      hist_addr;
    logic [COUNT_BITS-1:0] rd_zero;
    logic [COUNT_BITS-1:0] rd_one;
    logic                  hist_busy;

    brlh_hist #(
        .MAX_LEN    (MAX_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .i_addr    (hist_addr),
        .o_rd_zero (rd_zero),
        .o_rd_one  (rd_one),
        .o_busy    (hist_busy)
    );

    // Control outputs.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE) || r_hold_valid || hist_busy;
        out_free   = !r_out_valid || !i_out_stall;
    end

    assign in_fire = i_in_valid && !o_in_stall;
    assign idx_ok  = (i_in.length_index != '0) &&
                     (32'(i_in.length_index) <= 32'(MAX_LEN));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && hist_req.rd_en) begin
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Run tracking, memory requests and the result of this cycle.
    always_comb begin
        n_mem_read    = r_mem_read;
        n_started     = r_started;
        n_cur_bit     = r_cur_bit;
        n_cur_len     = r_cur_len;
        n_ovf         = r_ovf;
        n_longest     = r_longest;
        hist_req      = '0;
        hist_addr     = r_cur_len;
        cur_res_valid = 1'b0;
        cur_res       = '0;

        if (in_fire) begin
            n_mem_read = 1'b0;
            case (i_in.op)
                OP_SAMPLE: begin
                    if (!r_ovf) begin
                        if (!r_started) begin
                            n_started = 1'b1;
                            n_cur_bit = i_in.sample_bit;
                            n_cur_len = LEN_W'(1);
                        end else if (i_in.sample_bit == r_cur_bit) begin
                            if (r_cur_len >= LEN_W'(MAX_LEN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_cur_len = r_cur_len + LEN_W'(1);
                            end
                        end else begin
                            // The bit changed: the open run is complete.
                            hist_req.rd_en   = 1'b1;
                            hist_req.inc_en  = 1'b1;
                            hist_req.inc_bit = r_cur_bit;
                            hist_addr        = r_cur_len;
                            if (r_cur_len > r_longest) begin
                                n_longest = r_cur_len;
                            end
                            n_cur_bit = i_in.sample_bit;
                            n_cur_len = LEN_W'(1);
                        end
                    end
                    cur_res_valid       = 1'b1;
                    cur_res.longest_run = IDX_W'(n_longest);
                    cur_res.overflow    = n_ovf;
                end
                OP_READ: begin
                    if (idx_ok) begin
                        hist_req.rd_en = 1'b1;
                        hist_addr      = LEN_W'(i_in.length_index);
                        n_mem_read     = 1'b1;
                    end else begin
                        cur_res_valid       = 1'b1;
                        cur_res.longest_run = IDX_W'(r_longest);
                        cur_res.overflow    = r_ovf;
                    end
                end
                OP_CLEAR: begin
                    n_started          = 1'b0;
                    n_cur_bit          = 1'b0;
                    n_cur_len          = '0;
                    n_ovf              = 1'b0;
                    n_longest          = '0;
                    hist_req.clr_start = 1'b1;
                    cur_res_valid      = 1'b1;
                end
                default: begin
                    cur_res_valid       = 1'b1;
                    cur_res.longest_run = IDX_W'(r_longest);
                    cur_res.overflow    = r_ovf;
                end
            endcase
        end else if (r_state == ST_MEM && r_mem_read) begin
            cur_res_valid       = 1'b1;
            cur_res.zero_runs   = OUT_CNT_W'(rd_zero);
            cur_res.one_runs    = OUT_CNT_W'(rd_one);
            cur_res.longest_run = IDX_W'(r_longest);
            cur_res.overflow    = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mem_read   <= 1'b0;
            r_started    <= 1'b0;
            r_cur_bit    <= 1'b0;
            r_cur_len    <= '0;
            r_ovf        <= 1'b0;
            r_longest    <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mem_read <= n_mem_read;
            r_started  <= n_started;
            r_cur_bit  <= n_cur_bit;
            r_cur_len  <= n_cur_len;
            r_ovf      <= n_ovf;
            r_longest  <= n_longest;
            if (out_free) begin
                r_out_valid <= r_hold_valid || cur_res_valid;
            end
            if (cur_res_valid && !out_free) begin
                r_hold_valid <= 1'b1;
            end else if (r_hold_valid && out_free) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // The holding register is older than any new result, so it drains first.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_hold_valid) begin
                r_out <= r_hold;
            end else if (cur_res_valid) begin
                r_out <= cur_res;
            end
        end
        if (cur_res_valid && !out_free) begin
            r_hold <= cur_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A new result never arrives while an older one still waits in the holding register.
    a_no_hold_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hold_valid && cur_res_valid))
        else $error("new result while holding register is occupied");

    // A clear transfer starts the memory sweep, which stalls the input next cycle.
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == OP_CLEAR) |=> (hist_busy && o_in_stall))
        else $error("clear did not start the histogram sweep");

    // The memory access state always returns to idle in the next cycle.
    a_mem_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEM) |=> (r_state == ST_IDLE))
        else $error("memory access state did not return to idle");

    // Run lengths stay within the histogram, and no run is open before the first sample.
    a_len_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_len) <= 32'(MAX_LEN)) && (32'(r_longest) <= 32'(MAX_LEN)) &&
        (r_started || r_cur_len == '0))
        else $error("run length state out of range");

endmodule

FILE: tb/sv/brlh_checker.sv
// Checker for the run-length histogram block: predicts every result and compares it.
`timescale 1ns / 100ps
module brlh_checker
    import brlh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam int HIST_DEPTH = MAX_LEN_DEF + 1;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

    logic [COUNT_BITS_DEF-1:0] zero_runs_hist [HIST_DEPTH];
    logic [COUNT_BITS_DEF-1:0] one_runs_hist  [HIST_DEPTH];
    logic      open_bit;
    int        open_len;
    logic      run_open;
    logic      too_long;
    int        longest_len;
    t_out_item expected_results [$];
    int        fail_cnt = 0;
    int        checked_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    task automatic clear_histograms();
        for (int i = 0; i < HIST_DEPTH; i++) begin
            zero_runs_hist[i] = '0;
            one_runs_hist[i]  = '0;
        end
        open_bit    = 1'b0;
        open_len    = 0;
        run_open    = 1'b0;
        too_long    = 1'b0;
        longest_len = 0;
    endtask

    // Counts the run that just ended; counts stop at their maximum.
    task automatic close_run();
        if (open_len >= 1 && open_len <= MAX_LEN_DEF) begin
            if (open_bit == 1'b0) begin
                if (zero_runs_hist[open_len] != COUNT_TOP)
                    zero_runs_hist[open_len] = zero_runs_hist[open_len] + 1'b1;
            end else begin
                if (one_runs_hist[open_len] != COUNT_TOP)
                    one_runs_hist[open_len] = one_runs_hist[open_len] + 1'b1;
            end
            if (open_len > longest_len)
                longest_len = open_len;
        end
    endtask

    task automatic take_bit(input logic b);
        if (too_long) begin
            return;
        end
        if (!run_open) begin
            run_open = 1'b1;
            open_bit = b;
            open_len = 1;
        end else if (b == open_bit) begin
            if (open_len >= MAX_LEN_DEF)
                too_long = 1'b1;
            else
                open_len++;
        end else begin
            close_run();
            open_bit = b;
            open_len = 1;
        end
    endtask

    task automatic predict_result(input t_in_item it, output t_out_item res);
        int idx;
        res = '0;
        idx = int'(it.length_index);
        case (it.op)
            OP_SAMPLE: begin
                take_bit(it.sample_bit);
            end
            OP_READ: begin
                if (idx >= 1 && idx <= MAX_LEN_DEF) begin
                    res.zero_runs = OUT_CNT_W'(zero_runs_hist[idx]);
                    res.one_runs  = OUT_CNT_W'(one_runs_hist[idx]);
                end
            end
            OP_CLEAR: begin
                clear_histograms();
            end
            default: begin
            end
        endcase
        res.longest_run = IDX_W'(longest_len);
        res.overflow    = too_long;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_cnt++;
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        checked_cnt++;
        if (got.zero_runs !== want.zero_runs)
            report_mismatch("zero_runs", got.zero_runs, want.zero_runs);
        if (got.one_runs !== want.one_runs)
            report_mismatch("one_runs", got.one_runs, want.one_runs);
        if (got.longest_run !== want.longest_run)
            report_mismatch("longest_run", 32'(got.longest_run), 32'(want.longest_run));
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_histograms();
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_result(i_in, want);
                expected_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending", 32'd0, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    compare_result(want, i_out);
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the run-length histogram block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    import brlh_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    int   fail_count;
    int   pending;
    int   checked;
    int   hold_req = 0;
    int   burst_left = 0;
    bit   gap_free = 1'b0;
    int   n_samples = 0;
    int   n_reads = 0;
    int   n_clears = 0;
    int   n_unused = 0;

    always #10 i_clk = ~i_clk;

    binary_run_length_histogram_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    brlh_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic t_in_item make_item(input logic [1:0] op, input logic b,
                                           input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.op           = op;
        it.sample_bit   = b;
        it.length_index = idx;
        return it;
    endfunction

    // Offers one item until it transfers; at a burst's end it may then wait a random gap.
    task automatic put_item(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        case (it.op)
            OP_SAMPLE: n_samples++;
            OP_READ:   n_reads++;
            OP_CLEAR:  n_clears++;
            default:   n_unused++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = (gap_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_sample(input logic b);
        put_item(make_item(OP_SAMPLE, b, IDX_W'($urandom_range(0, 1023))));
    endtask

    task automatic send_read(input logic [IDX_W-1:0] idx);
        put_item(make_item(OP_READ, 1'($urandom_range(0, 1)), idx));
    endtask

    task automatic send_clear();
        put_item(make_item(OP_CLEAR, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 1023))));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: stall patterns in segments, plus a long hold-off whenever one is requested.
    initial begin
        int mode;
        int seg;
        int holds_done;
        holds_done = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req != holds_done) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                seg  = $urandom_range(10, 120);
                repeat (seg) begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 3) == 0);
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int total;
        int pick;
        int run_len;
        int r;
        int lim;
        logic b;
        logic last_bit;
        bit second_hold;
        bit paused;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short hand-made sequence: fresh reads, unused op, a few runs, index edges, clear.
        send_read(IDX_W'(1));
        put_item(make_item(OP_UNUSED, 1'b1, '1));
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_read(IDX_W'(2));
        send_read(IDX_W'(3));
        send_read('0);
        send_read('1);
        send_sample(1'b0);
        send_read(IDX_W'(2));
        send_clear();
        send_read(IDX_W'(2));
        send_sample(1'b1);
        send_sample(1'b0);
        send_read(IDX_W'(1));
        put_item(make_item(OP_UNUSED, 1'b0, '0));
        wait_idle();

        // A one-run that reaches the longest allowed length and then grows past it.
        gap_free = 1'b1;
        hold_req <= hold_req + 1;
        repeat (MAX_LEN_DEF + 1) send_sample(1'b1);
        gap_free = 1'b0;
        repeat (4) send_sample(1'($urandom_range(0, 1)));
        send_read(IDX_W'(MAX_LEN_DEF));
        send_read(IDX_W'(1));
        send_clear();

        // Random part: mostly runs of random length, mixed with reads, unused ops and a few clears.
        total       = 0;
        second_hold = 1'b0;
        paused      = 1'b0;
        last_bit    = 1'($urandom_range(0, 1));
        while (total < RANDOM_ITEMS) begin
            gap_free = (total >= 20 && total < 40);
            if (!second_hold && total >= 40) begin
                second_hold = 1'b1;
                hold_req <= hold_req + 1;
            end
            if (!paused && total >= 60) begin
                paused = 1'b1;
                wait_idle();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    run_len = $urandom_range(1, 6);
                else if (r < 19)
                    run_len = $urandom_range(7, 40);
                else
                    run_len = $urandom_range(41, 200);
                b = ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : ~last_bit;
                repeat (run_len) send_sample(b);
                last_bit = b;
                total += run_len;
            end else if (pick < 87) begin
                if ($urandom_range(0, 4) != 0)
                    send_read(IDX_W'($urandom_range(1, 16)));
                else
                    send_read(IDX_W'($urandom_range(0, 1023)));
                total++;
            end else if (pick < 95) begin
                put_item(make_item(OP_UNUSED, 1'($urandom_range(0, 1)),
                                   IDX_W'($urandom_range(0, 1023))));
            end else begin
                send_clear();
                total++;
            end
        end

        i_in_valid <= 1'b0;
        lim = 0;
        while (pending != 0 && lim < DRAIN_LIMIT) begin
            @(posedge i_clk);
            lim++;
        end
        repeat (8) @(posedge i_clk);

        $display("Covered %0d samples, %0d reads, %0d clears and %0d unused-op items;",
                 n_samples, n_reads, n_clears, n_unused);
        $display("%0d results compared, including a run driven past the maximum length.",
                 checked);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout: the block stopped making progress");
        $display("Test completed with failures");
        $finish;
    end

endmodule
